// ===== hdl/sct_pkg.sv =====
// Types, codes and constants shared by the snapshot change tracker files.
package sct_pkg;

   localparam int TABLE_DEPTH_DEF = 32;
   localparam logic [13:0] RATE_MIN = 14'd10;
   localparam logic [13:0] RATE_MAX = 14'd10000;

   typedef enum logic [1:0] {
      OP_BEGIN  = 2'd0,
      OP_REPORT = 2'd1,
      OP_END    = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_HEADER  = 3'd0,
      KIND_NEW     = 3'd1,
      KIND_CHANGED = 3'd2,
      KIND_DELETED = 3'd3,
      KIND_FULL    = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLR_RD,
      ST_CLR_WR,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_INSERT,
      ST_INS_CHG,
      ST_SWEEP_RD,
      ST_SWEEP_CHK,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_EMIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [31:0] key;
      logic [30:0] size;
      logic [30:0] high_water;
      logic        seen;
   } entry_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] key;
      logic [30:0] size;
      logic [30:0] high_water;
      logic [30:0] capacity;
      logic [31:0] period;
      logic [13:0] rate;
   } record_type;

endpackage

// ===== hdl/sct_table.sv =====
// Entry table memory with one write port and one registered read port.
module sct_table import sct_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int AW = $clog2(TABLE_DEPTH)
) (
   input  logic          clock,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data
);

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/snapshot_change_tracker.sv =====
// Top level of the snapshot change tracker: sequencer around the sorted entry table.
//
//  channel  direction  tdata / data                         tuser / tlast
//  req_     in         key, size, capacity                  operation
//  rsp_     out        key, size, high water, capacity,     kind, last record
//                      period, rate
//  csr_     in         sample rate                          -
//
// One item is taken at a time. A begin reads and rewrites every stored entry, a
// report searches the entries linearly and moves entries up on insertion, and an
// end checks every entry and moves entries down on each deletion; the cost of each
// is set by the single read and write port of the table.
// A stalled result side holds the sequencer once two records wait.
// Reset is synchronous and empties the table at once; no clearing pass is needed.
module snapshot_change_tracker import sct_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,  // object_key, object_size, object_capacity, zero fill
   input  logic [1:0]   req_tuser,  // operation
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [175:0] rsp_tdata,  // key, size, high water, capacity, period, rate, zero fill
   output logic [2:0]   rsp_tuser,  // record_kind
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [13:0]  csr_data
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   state_type   state_ff, state_in, ret_ff, ret_in;
   logic [CW-1:0] idx_ff, idx_in, jdx_ff, jdx_in, count_ff, count_in;
   logic [31:0] period_ff, period_in;
   logic        hdr_ff, hdr_in;
   logic [13:0] rate_ff, rate_in;
   logic [31:0] key_ff, key_in;
   logic [30:0] size_ff, size_in, cap_ff, cap_in;
   record_type  pend_ff, pend_in, hold_ff, hold_in, out_ff, out_in;
   logic        hold_v_ff, hold_v_in, out_v_ff, out_v_in, last_ff, last_in;

   logic [AW-1:0] rd_addr, wr_addr;
   logic        wr_en;
   entry_type   rd_data, wr_data;
   record_type  hdr_rec, push_rec;
   logic [13:0] rate_clamped;
   logic        req_acc, can_push, full, key_lt, key_eq, size_ne;
   logic [30:0] new_hw;
   state_type   nf_state;

   sct_table #(.TABLE_DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
      .clock  (clock),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign can_push   = !hold_v_ff || !out_v_ff || rsp_tready;
   assign full       = (count_ff == CW'(TABLE_DEPTH));
   assign key_lt     = rd_data.key < key_ff;
   assign key_eq     = rd_data.key == key_ff;
   assign size_ne    = rd_data.size != size_ff;
   assign new_hw     = (size_ff > rd_data.high_water) ? size_ff : rd_data.high_water;
   assign nf_state   = full ? ST_EMIT : ((count_ff == idx_ff) ? ST_INSERT : ST_SHIFT_RD);

   always_comb begin
      if (rate_ff < RATE_MIN) begin
         rate_clamped = RATE_MIN;
      end else if (rate_ff > RATE_MAX) begin
         rate_clamped = RATE_MAX;
      end else begin
         rate_clamped = rate_ff;
      end
      hdr_rec = '{kind: KIND_HEADER, key: '0, size: '0, high_water: '0, capacity: '0,
                  period: period_ff, rate: rate_clamped};
      push_rec = hdr_ff ? pend_ff : hdr_rec;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               unique case (op_type'(req_tuser))
                  OP_BEGIN:  state_in = (count_ff == '0) ? ST_DONE : ST_CLR_RD;
                  OP_REPORT: state_in = ST_SRCH_RD;
                  OP_END:    state_in = ST_SWEEP_RD;
                  OP_CLEAR:  state_in = ST_DONE;
               endcase
            end
         end
         ST_CLR_RD:   state_in = ST_CLR_WR;
         ST_CLR_WR:   state_in = (idx_ff + 1'b1 == count_ff) ? ST_DONE : ST_CLR_RD;
         ST_SRCH_RD:  state_in = (idx_ff < count_ff) ? ST_SRCH_CMP : nf_state;
         ST_SRCH_CMP: begin
            priority if (key_lt) begin
               state_in = ST_SRCH_RD;
            end else if (key_eq) begin
               state_in = size_ne ? ST_EMIT : ST_DONE;
            end else begin
               state_in = nf_state;
            end
         end
         ST_SHIFT_RD:  state_in = ST_SHIFT_WR;
         ST_SHIFT_WR:  state_in = (jdx_ff - 1'b1 == idx_ff) ? ST_INSERT : ST_SHIFT_RD;
         ST_INSERT:    state_in = ST_EMIT;
         ST_INS_CHG:   state_in = ST_EMIT;
         ST_SWEEP_RD:  state_in = (idx_ff == '0) ? ST_DONE : ST_SWEEP_CHK;
         ST_SWEEP_CHK: state_in = rd_data.seen ? ST_SWEEP_RD : ST_EMIT;
         ST_DEL_RD:    state_in = (jdx_ff + 1'b1 < count_ff) ? ST_DEL_WR : ST_SWEEP_RD;
         ST_DEL_WR:    state_in = ST_DEL_RD;
         ST_EMIT:      state_in = (can_push && hdr_ff) ? ret_ff : ST_EMIT;
         ST_DONE:      state_in = (!hold_v_ff || !out_v_ff || rsp_tready) ? ST_IDLE : ST_DONE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Datapath, table accesses and record buffering.
   always_comb begin
      idx_in    = idx_ff;
      jdx_in    = jdx_ff;
      count_in  = count_ff;
      period_in = period_ff;
      hdr_in    = hdr_ff;
      rate_in   = (csr_valid && csr_ready) ? csr_data : rate_ff;
      key_in    = key_ff;
      size_in   = size_ff;
      cap_in    = cap_ff;
      pend_in   = pend_ff;
      ret_in    = ret_ff;
      hold_in   = hold_ff;
      hold_v_in = hold_v_ff;
      out_in    = out_ff;
      last_in   = last_ff;
      out_v_in  = out_v_ff && !rsp_tready;
      rd_addr   = idx_ff[AW-1:0];
      wr_en     = 1'b0;
      wr_addr   = idx_ff[AW-1:0];
      wr_data   = rd_data;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               key_in  = req_tdata[31:0];
               size_in = req_tdata[62:32];
               cap_in  = req_tdata[93:63];
               idx_in  = '0;
               unique case (op_type'(req_tuser))
                  OP_BEGIN: begin
                     period_in = period_ff + 32'd1;
                     hdr_in    = 1'b0;
                  end
                  OP_REPORT: ;
                  OP_END:   idx_in = count_ff;
                  OP_CLEAR: count_in = '0;
               endcase
            end
         end
         ST_CLR_RD: ;
         ST_CLR_WR: begin
            wr_en        = 1'b1;
            wr_data.seen = 1'b0;
            idx_in       = idx_ff + 1'b1;
         end
         ST_SRCH_RD: begin
            jdx_in = count_ff;
            if (!(idx_ff < count_ff) && full) begin
               pend_in = '{kind: KIND_FULL, key: key_ff, default: '0};
               ret_in  = ST_DONE;
            end
         end
         ST_SRCH_CMP: begin
            jdx_in = count_ff;
            priority if (key_lt) begin
               idx_in = idx_ff + 1'b1;
            end else if (key_eq) begin
               wr_en        = 1'b1;
               wr_data.seen = 1'b1;
               if (size_ne) begin
                  wr_data.size       = size_ff;
                  wr_data.high_water = new_hw;
                  pend_in = '{kind: KIND_CHANGED, key: key_ff, size: size_ff,
                              high_water: new_hw, default: '0};
                  ret_in  = ST_DONE;
               end
            end else if (full) begin
               pend_in = '{kind: KIND_FULL, key: key_ff, default: '0};
               ret_in  = ST_DONE;
            end
         end
         ST_SHIFT_RD: rd_addr = AW'(jdx_ff - 1'b1);
         ST_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = jdx_ff[AW-1:0];
            jdx_in  = jdx_ff - 1'b1;
         end
         ST_INSERT: begin
            wr_en   = 1'b1;
            wr_data = '{key: key_ff, size: size_ff, high_water: size_ff, seen: 1'b1};
            count_in = count_ff + 1'b1;
            pend_in = '{kind: KIND_NEW, key: key_ff, capacity: cap_ff, default: '0};
            ret_in  = ST_INS_CHG;
         end
         ST_INS_CHG: begin
            pend_in = '{kind: KIND_CHANGED, key: key_ff, size: size_ff,
                        high_water: size_ff, default: '0};
            ret_in  = ST_DONE;
         end
         ST_SWEEP_RD: begin
            rd_addr = AW'(idx_ff - 1'b1);
            if (idx_ff != '0) begin
               idx_in = idx_ff - 1'b1;
            end
         end
         ST_SWEEP_CHK: begin
            jdx_in  = idx_ff;
            pend_in = '{kind: KIND_DELETED, key: rd_data.key, default: '0};
            ret_in  = ST_DEL_RD;
         end
         ST_DEL_RD: begin
            rd_addr = AW'(jdx_ff + 1'b1);
            if (!(jdx_ff + 1'b1 < count_ff)) begin
               count_in = count_ff - 1'b1;
            end
         end
         ST_DEL_WR: begin
            wr_en   = 1'b1;
            wr_addr = jdx_ff[AW-1:0];
            jdx_in  = jdx_ff + 1'b1;
         end
         ST_EMIT: begin
            if (can_push) begin
               hdr_in = 1'b1;
               if (hold_v_ff) begin
                  out_in   = hold_ff;
                  last_in  = 1'b0;
                  out_v_in = 1'b1;
               end
               hold_in   = push_rec;
               hold_v_in = 1'b1;
            end
         end
         ST_DONE: begin
            if (hold_v_ff && (!out_v_ff || rsp_tready)) begin
               out_in    = hold_ff;
               last_in   = 1'b1;
               out_v_in  = 1'b1;
               hold_v_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         period_ff <= '1;
         hdr_ff    <= 1'b0;
         rate_ff   <= RATE_MIN;
         hold_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         period_ff <= period_in;
         hdr_ff    <= hdr_in;
         rate_ff   <= rate_in;
         hold_v_ff <= hold_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff  <= ret_in;
      idx_ff  <= idx_in;
      jdx_ff  <= jdx_in;
      key_ff  <= key_in;
      size_ff <= size_in;
      cap_ff  <= cap_in;
      pend_ff <= pend_in;
      hold_ff <= hold_in;
      out_ff  <= out_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {5'b0, out_ff.rate, out_ff.period, out_ff.capacity,
                        out_ff.high_water, out_ff.size, out_ff.key};

endmodule

// ===== hdl/sct_checker.sv =====
// Port-level checks for the snapshot change tracker, bound to the top level.
module sct_checker import sct_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [175:0] rsp_tdata,
   input logic [2:0]   rsp_tuser,
   input logic         rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_header_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_HEADER |-> rsp_tdata[31:0] == 32'd0 && !rsp_tlast)
      else $error("header record malformed or marked last");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while one is in work");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind snapshot_change_tracker sct_checker u_sct_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser),
   .rsp_tlast (rsp_tlast)
);
